// ===== design/cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared widths, reset values and defaults for the camera basis builder.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int CBB_FRAC_BITS = 16;     // default fraction bits
  localparam int CBB_IN_W      = 32;     // position / target field width
  localparam int CBB_FWD_W     = 18;     // forward field width
  localparam int CBB_BASIS_W   = 20;     // right / up field width
  localparam int CBB_SCALE_W   = 19;     // basis_scale register width
  localparam int CBB_R_W       = 21;     // internal scaled component, signed
  localparam int CBB_NORM_W    = 31;     // normalized magnitude width
  localparam int CBB_ROOT_W    = 32;     // square root result width

  localparam logic [CBB_SCALE_W-1:0] CBB_SCALE_RESET = 19'd98304;

endpackage

// ===== design/cbb_if.sv =====
// ----------------------------------------------------------------------------
// cbb_if
// Valid/ready channels for camera setups in and basis vectors out.
// ----------------------------------------------------------------------------
interface cbb_in_if import cbb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CBB_IN_W-1:0] position_x;
  logic signed [CBB_IN_W-1:0] position_y;
  logic signed [CBB_IN_W-1:0] position_z;
  logic signed [CBB_IN_W-1:0] target_x;
  logic signed [CBB_IN_W-1:0] target_y;
  logic signed [CBB_IN_W-1:0] target_z;

  modport source (
    output valid, position_x, position_y, position_z, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, position_x, position_y, position_z, target_x, target_y, target_z,
    output ready
  );
endinterface

interface cbb_out_if import cbb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [CBB_FWD_W-1:0]   forward_x;
  logic signed [CBB_FWD_W-1:0]   forward_y;
  logic signed [CBB_FWD_W-1:0]   forward_z;
  logic signed [CBB_BASIS_W-1:0] right_x;
  logic signed [CBB_BASIS_W-1:0] right_y;
  logic signed [CBB_BASIS_W-1:0] right_z;
  logic signed [CBB_BASIS_W-1:0] up_x;
  logic signed [CBB_BASIS_W-1:0] up_y;
  logic signed [CBB_BASIS_W-1:0] up_z;

  modport source (
    output valid, forward_x, forward_y, forward_z, right_x, right_y, right_z,
           up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, forward_x, forward_y, forward_z, right_x, right_y, right_z,
           up_x, up_y, up_z,
    output ready
  );
endinterface

// ===== design/cbb_unit_vec.sv =====
// ----------------------------------------------------------------------------
// cbb_unit_vec
// Pipelined 3-vector normalize: magnitude, common shift, sum of squares,
// bit-per-stage square root and bit-per-stage rounding divide per lane.
// ----------------------------------------------------------------------------
module cbb_unit_vec import cbb_pkg::*; #(
  parameter int FRAC_BITS = CBB_FRAC_BITS,
  parameter int IN_W      = CBB_IN_W,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [IN_W-1:0]      in_v [3],
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_n [3],
  output logic [SIDE_W-1:0]           out_side
);

  localparam int X_W   = (IN_W > CBB_NORM_W) ? IN_W : CBB_NORM_W;
  localparam int XP_W  = ((X_W + 7) / 8) * 8;
  localparam int GRP   = XP_W / 8;
  localparam int K_W   = $clog2(GRP + 1);
  localparam int SQ_N  = CBB_ROOT_W;
  localparam int SUM_W = 2 * CBB_ROOT_W;
  localparam int SQ_W  = 2 * CBB_NORM_W;
  localparam int REM_W = CBB_ROOT_W + 1;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int N_W   = FRAC_BITS + CBB_NORM_W + 1;
  localparam int OUT_W = FRAC_BITS + 2;

  // stage A: magnitudes and OR of all three
  logic              a_valid_r;
  logic [XP_W-1:0]   a_m_r [3];
  logic [2:0]        a_neg_r;
  logic [XP_W-1:0]   a_or_r;
  logic [SIDE_W-1:0] a_side_r;
  logic [XP_W-1:0]   a_m_nxt [3];
  logic [XP_W-1:0]   a_or_nxt;

  always_comb begin
    logic [IN_W-1:0] mag;
    a_or_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag = $unsigned(in_v[i]);
      if (in_v[i][IN_W-1]) mag = ~mag + 1'b1;
      a_m_nxt[i] = XP_W'(mag);
      a_or_nxt   = a_or_nxt | a_m_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m_r    <= a_m_nxt;
      a_or_r   <= a_or_nxt;
      a_side_r <= in_side;
      for (int i = 0; i < 3; i++) a_neg_r[i] <= in_v[i][IN_W-1];
    end
  end

  // stage B: coarse shift by whole bytes
  logic              b_valid_r;
  logic [XP_W-1:0]   b_m_r [3];
  logic [2:0]        b_neg_r;
  logic [XP_W-1:0]   b_or_r;
  logic [SIDE_W-1:0] b_side_r;
  logic [K_W-1:0]    b_k;

  always_comb begin
    b_k = K_W'(GRP);
    for (int g = 0; g < GRP; g++) begin
      if (a_or_r[g*8 +: 8] != 8'd0) b_k = K_W'(GRP - 1 - g);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) b_m_r[i] <= a_m_r[i] << {b_k, 3'b000};
      b_or_r   <= a_or_r << {b_k, 3'b000};
      b_neg_r  <= a_neg_r;
      b_side_r <= a_side_r;
    end
  end

  // stage C: fine shift, then take the 31-bit window so the max is in [2^30, 2^31)
  logic                  c_valid_r;
  logic [CBB_NORM_W-1:0] c_m_r [3];
  logic [2:0]            c_neg_r;
  logic                  c_zero_r;
  logic [SIDE_W-1:0]     c_side_r;
  logic [2:0]            c_lz;
  logic [CBB_NORM_W-1:0] c_m_nxt [3];

  always_comb begin
    logic [XP_W-1:0] sh;
    c_lz = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (b_or_r[XP_W-8+b]) c_lz = 3'(7 - b);
    end
    for (int i = 0; i < 3; i++) begin
      sh         = b_m_r[i] << c_lz;
      c_m_nxt[i] = sh[XP_W-1 -: CBB_NORM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_m_r    <= c_m_nxt;
      c_neg_r  <= b_neg_r;
      c_zero_r <= ~|b_or_r;
      c_side_r <= b_side_r;
    end
  end

  // stage D: squares
  logic                  d_valid_r;
  logic [SQ_W-1:0]       d_sq_r [3];
  logic [CBB_NORM_W-1:0] d_m_r [3];
  logic [2:0]            d_neg_r;
  logic                  d_zero_r;
  logic [SIDE_W-1:0]     d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_sq_r[i] <= SQ_W'(c_m_r[i]) * SQ_W'(c_m_r[i]);
      d_m_r    <= c_m_r;
      d_neg_r  <= c_neg_r;
      d_zero_r <= c_zero_r;
      d_side_r <= c_side_r;
    end
  end

  // square root pipeline; index 0 holds the sum of squares
  logic                  sq_valid_r [SQ_N+1];
  logic [SUM_W-1:0]      sq_x_r     [SQ_N+1];
  logic [REM_W-1:0]      sq_rem_r   [SQ_N+1];
  logic [SQ_N-1:0]       sq_root_r  [SQ_N+1];
  logic [CBB_NORM_W-1:0] sq_m_r     [SQ_N+1][3];
  logic [2:0]            sq_neg_r   [SQ_N+1];
  logic                  sq_zero_r  [SQ_N+1];
  logic [SIDE_W-1:0]     sq_side_r  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else if (en) begin
      sq_valid_r[0] <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]    <= SUM_W'(d_sq_r[0]) + SUM_W'(d_sq_r[1]) + SUM_W'(d_sq_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_m_r[0]    <= d_m_r;
      sq_neg_r[0]  <= d_neg_r;
      sq_zero_r[0] <= d_zero_r;
      sq_side_r[0] <= d_side_r;
    end
  end

  for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    assign rem_sh = {sq_rem_r[k-1], sq_x_r[k-1][2*(SQ_N-k) +: 2]};
    assign trial  = {1'b0, sq_root_r[k-1], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k] <= 1'b0;
      end else if (en) begin
        sq_valid_r[k] <= sq_valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[k]    <= sq_x_r[k-1];
        sq_rem_r[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        sq_root_r[k] <= {sq_root_r[k-1][SQ_N-2:0], take};
        sq_m_r[k]    <= sq_m_r[k-1];
        sq_neg_r[k]  <= sq_neg_r[k-1];
        sq_zero_r[k] <= sq_zero_r[k-1];
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // divide pipeline: q = (m << FRAC_BITS + s/2) / s, one quotient bit per stage
  logic                  dv_valid_r [Q_W+1];
  logic [N_W-1:0]        dv_num_r   [Q_W+1][3];
  logic [SQ_N-1:0]       dv_rem_r   [Q_W+1][3];
  logic [Q_W-1:0]        dv_q_r     [Q_W+1][3];
  logic [SQ_N-1:0]       dv_s_r     [Q_W+1];
  logic [2:0]            dv_neg_r   [Q_W+1];
  logic                  dv_zero_r  [Q_W+1];
  logic [SIDE_W-1:0]     dv_side_r  [Q_W+1];
  logic [N_W-1:0]        dv_num_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num_nxt[i] = (N_W'(sq_m_r[SQ_N][i]) << FRAC_BITS)
                    + N_W'(sq_root_r[SQ_N][SQ_N-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= sq_valid_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_num_r[0][i] <= dv_num_nxt[i];
        // top bits already sit below s since m <= s
        dv_rem_r[0][i] <= SQ_N'(dv_num_nxt[i][N_W-1:Q_W]);
        dv_q_r[0][i]   <= '0;
      end
      dv_s_r[0]    <= sq_root_r[SQ_N];
      dv_neg_r[0]  <= sq_neg_r[SQ_N];
      dv_zero_r[0] <= sq_zero_r[SQ_N];
      dv_side_r[0] <= sq_side_r[SQ_N];
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    logic [SQ_N:0]   rem_sh [3];
    logic [2:0]      ge;
    logic [SQ_N-1:0] rem_nxt [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_sh[i]  = {dv_rem_r[k-1][i], dv_num_r[k-1][i][Q_W-k]};
        ge[i]      = (rem_sh[i] >= {1'b0, dv_s_r[k-1]});
        rem_nxt[i] = ge[i] ? SQ_N'(rem_sh[i] - {1'b0, dv_s_r[k-1]}) : SQ_N'(rem_sh[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else if (en) begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_num_r[k][i] <= dv_num_r[k-1][i];
          dv_rem_r[k][i] <= rem_nxt[i];
          dv_q_r[k][i]   <= {dv_q_r[k-1][i][Q_W-2:0], ge[i]};
        end
        dv_s_r[k]    <= dv_s_r[k-1];
        dv_neg_r[k]  <= dv_neg_r[k-1];
        dv_zero_r[k] <= dv_zero_r[k-1];
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // sign back on, zero-length input gives the zero vector
  logic                    fin_valid_r;
  logic signed [OUT_W-1:0] fin_n_r [3];
  logic [SIDE_W-1:0]       fin_side_r;
  logic signed [OUT_W-1:0] fin_n_nxt [3];

  always_comb begin
    logic signed [OUT_W-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({1'b0, dv_q_r[Q_W][i]});
      if (dv_zero_r[Q_W])        fin_n_nxt[i] = '0;
      else if (dv_neg_r[Q_W][i]) fin_n_nxt[i] = -qs;
      else                       fin_n_nxt[i] = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= dv_valid_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_n_r    <= fin_n_nxt;
      fin_side_r <= dv_side_r[Q_W];
    end
  end

  assign out_valid = fin_valid_r;
  assign out_n     = fin_n_r;
  assign out_side  = fin_side_r;

endmodule

// ===== design/cbb_scale.sv =====
// ----------------------------------------------------------------------------
// cbb_scale
// Two-stage scaling of a unit vector by basis_scale, rounding half away
// from zero.
// ----------------------------------------------------------------------------
module cbb_scale import cbb_pkg::*; #(
  parameter int FRAC_BITS = CBB_FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [FRAC_BITS+1:0] in_n [3],
  input  logic [CBB_SCALE_W-1:0]      scale,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic signed [CBB_R_W-1:0]   out_r [3],
  output logic [SIDE_W-1:0]           out_side
);

  localparam int N_W = FRAC_BITS + 2;
  localparam int M_W = FRAC_BITS + 1;
  localparam int P_W = M_W + CBB_SCALE_W;

  logic              p_valid_r;
  logic [P_W-1:0]    p_prod_r [3];
  logic [2:0]        p_neg_r;
  logic [SIDE_W-1:0] p_side_r;
  logic [P_W-1:0]    p_prod_nxt [3];

  always_comb begin
    logic [N_W-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = $unsigned(in_n[i]);
      if (in_n[i][N_W-1]) mag = ~mag + 1'b1;
      p_prod_nxt[i] = P_W'(mag[M_W-1:0]) * P_W'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod_r <= p_prod_nxt;
      p_side_r <= in_side;
      for (int i = 0; i < 3; i++) p_neg_r[i] <= in_n[i][N_W-1];
    end
  end

  logic                      r_valid_r;
  logic signed [CBB_R_W-1:0] r_r [3];
  logic [SIDE_W-1:0]         r_side_r;
  logic signed [CBB_R_W-1:0] r_nxt [3];

  always_comb begin
    logic [P_W:0]              rnd;
    logic signed [CBB_R_W-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      rnd      = (P_W+1)'(p_prod_r[i]) + ((P_W+1)'(1) << (FRAC_BITS - 1));
      qs       = $signed(CBB_R_W'(rnd >> FRAC_BITS));
      r_nxt[i] = p_neg_r[i] ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (en) begin
      r_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r      <= r_nxt;
      r_side_r <= p_side_r;
    end
  end

  assign out_valid = r_valid_r;
  assign out_r     = r_r;
  assign out_side  = r_side_r;

endmodule

// ===== design/camera_basis_builder.sv =====
// ----------------------------------------------------------------------------
// camera_basis_builder
// Look-at camera basis (forward, right, up) in signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one camera setup per clock while the skid is empty,
// each giving one result transfer. Each of the three normalize units
// has a 32-stage square root and a FRAC_BITS+1 stage divider per lane.
// A two-entry output register/skid pair lets the pipeline keep accepting
// while a result waits; the whole pipeline holds only when both are full.
// basis_scale is written through cfg_we/cfg_wdata and should change only
// while no item is in flight.
module camera_basis_builder import cbb_pkg::*; #(
  parameter int FRAC_BITS = CBB_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  cbb_in_if.sink                 in_chan,
  cbb_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [CBB_SCALE_W-1:0] cfg_wdata
);

  localparam int F2    = FRAC_BITS + 2;
  localparam int PR_W  = F2 + CBB_R_W;
  localparam int T3_W  = PR_W + 1;
  localparam int SF_W  = 3 * F2;
  localparam int SFR_W = SF_W + 3 * CBB_R_W;
  localparam logic signed [F2-1:0] F_ONE = F2'(1) << FRAC_BITS;

  logic                   en;
  logic [CBB_SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= CBB_SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // target - position, saturated
  logic                       d_valid_r;
  logic signed [CBB_IN_W-1:0] d_r [3];
  logic signed [CBB_IN_W-1:0] pos [3];
  logic signed [CBB_IN_W-1:0] tgt [3];
  logic signed [CBB_IN_W-1:0] d_nxt [3];

  assign pos[0] = in_chan.position_x;
  assign pos[1] = in_chan.position_y;
  assign pos[2] = in_chan.position_z;
  assign tgt[0] = in_chan.target_x;
  assign tgt[1] = in_chan.target_y;
  assign tgt[2] = in_chan.target_z;

  always_comb begin
    logic signed [CBB_IN_W:0] df;
    for (int i = 0; i < 3; i++) begin
      df = (CBB_IN_W+1)'(tgt[i]) - (CBB_IN_W+1)'(pos[i]);
      if (df[CBB_IN_W] != df[CBB_IN_W-1]) begin
        d_nxt[i] = df[CBB_IN_W] ? {1'b1, {(CBB_IN_W-1){1'b0}}} : {1'b0, {(CBB_IN_W-1){1'b1}}};
      end else begin
        d_nxt[i] = df[CBB_IN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  // forward
  logic                 f_valid;
  logic signed [F2-1:0] f_n [3];

  cbb_unit_vec #(.FRAC_BITS(FRAC_BITS), .IN_W(CBB_IN_W), .SIDE_W(1)) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid_r),
    .in_v      (d_r),
    .in_side   (1'b0),
    .out_valid (f_valid),
    .out_n     (f_n),
    .out_side  ()
  );

  // cross(forward, down) = (f_z, 0, -f_x)
  logic signed [F2-1:0] t2 [3];
  logic                 n2_valid;
  logic signed [F2-1:0] n2 [3];
  logic [SF_W-1:0]      n2_side;

  assign t2[0] = f_n[2];
  assign t2[1] = '0;
  assign t2[2] = -f_n[0];

  cbb_unit_vec #(.FRAC_BITS(FRAC_BITS), .IN_W(F2), .SIDE_W(SF_W)) u_right_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_v      (t2),
    .in_side   ({f_n[2], f_n[1], f_n[0]}),
    .out_valid (n2_valid),
    .out_n     (n2),
    .out_side  (n2_side)
  );

  logic                      r_valid;
  logic signed [CBB_R_W-1:0] r_n [3];
  logic [SF_W-1:0]           r_side;

  cbb_scale #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SF_W)) u_right_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n2_valid),
    .in_n      (n2),
    .scale     (scale_r),
    .in_side   (n2_side),
    .out_valid (r_valid),
    .out_r     (r_n),
    .out_side  (r_side)
  );

  // cross(forward, right), full precision
  logic                      x1_valid_r;
  logic signed [PR_W-1:0]    x1_p_r [4];
  logic signed [F2-1:0]      x1_f_r [3];
  logic signed [CBB_R_W-1:0] x1_r_r [3];
  logic signed [F2-1:0]      rf [3];

  for (genvar i = 0; i < 3; i++) begin : g_rf
    assign rf[i] = $signed(r_side[i*F2 +: F2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_valid_r <= 1'b0;
    end else if (en) begin
      x1_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p_r[0] <= PR_W'(rf[1]) * PR_W'(r_n[2]);
      x1_p_r[1] <= PR_W'(rf[2]) * PR_W'(r_n[0]);
      x1_p_r[2] <= PR_W'(rf[0]) * PR_W'(r_n[2]);
      x1_p_r[3] <= PR_W'(rf[1]) * PR_W'(r_n[0]);
      x1_f_r    <= rf;
      x1_r_r    <= r_n;
    end
  end

  logic                   x2_valid_r;
  logic signed [T3_W-1:0] x2_t_r [3];
  logic [SFR_W-1:0]       x2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_valid_r <= 1'b0;
    end else if (en) begin
      x2_valid_r <= x1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_t_r[0] <= T3_W'(x1_p_r[0]);
      x2_t_r[1] <= T3_W'(x1_p_r[1]) - T3_W'(x1_p_r[2]);
      x2_t_r[2] <= -T3_W'(x1_p_r[3]);
      x2_side_r <= {x1_r_r[2], x1_r_r[1], x1_r_r[0], x1_f_r[2], x1_f_r[1], x1_f_r[0]};
    end
  end

  logic                 n3_valid;
  logic signed [F2-1:0] n3 [3];
  logic [SFR_W-1:0]     n3_side;

  cbb_unit_vec #(.FRAC_BITS(FRAC_BITS), .IN_W(T3_W), .SIDE_W(SFR_W)) u_up_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_valid_r),
    .in_v      (x2_t_r),
    .in_side   (x2_side_r),
    .out_valid (n3_valid),
    .out_n     (n3),
    .out_side  (n3_side)
  );

  logic                      u_valid;
  logic signed [CBB_R_W-1:0] u_n [3];
  logic [SFR_W-1:0]          u_side;

  cbb_scale #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SFR_W)) u_up_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n3_valid),
    .in_n      (n3),
    .scale     (scale_r),
    .in_side   (n3_side),
    .out_valid (u_valid),
    .out_r     (u_n),
    .out_side  (u_side)
  );

  // result fields at port widths
  logic [CBB_FWD_W-1:0]   p_fwd [3];
  logic [CBB_BASIS_W-1:0] p_right [3];
  logic [CBB_BASIS_W-1:0] p_up [3];

  for (genvar i = 0; i < 3; i++) begin : g_pay
    assign p_fwd[i]   = CBB_FWD_W'($signed(u_side[i*F2 +: F2]));
    assign p_right[i] = CBB_BASIS_W'($signed(u_side[SF_W + i*CBB_R_W +: CBB_R_W]));
    assign p_up[i]    = CBB_BASIS_W'(u_n[i]);
  end

  // output register plus skid
  logic                   out_valid_r;
  logic [CBB_FWD_W-1:0]   out_fwd_r [3];
  logic [CBB_BASIS_W-1:0] out_right_r [3];
  logic [CBB_BASIS_W-1:0] out_up_r [3];
  logic                   skid_valid_r;
  logic [CBB_FWD_W-1:0]   skid_fwd_r [3];
  logic [CBB_BASIS_W-1:0] skid_right_r [3];
  logic [CBB_BASIS_W-1:0] skid_up_r [3];

  assign en            = ~skid_valid_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_chan.ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (u_valid) begin
      if (!out_valid_r || out_chan.ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_chan.ready) begin
        out_fwd_r   <= skid_fwd_r;
        out_right_r <= skid_right_r;
        out_up_r    <= skid_up_r;
      end
    end else if (u_valid) begin
      if (!out_valid_r || out_chan.ready) begin
        out_fwd_r   <= p_fwd;
        out_right_r <= p_right;
        out_up_r    <= p_up;
      end else begin
        skid_fwd_r   <= p_fwd;
        skid_right_r <= p_right;
        skid_up_r    <= p_up;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.forward_x = out_fwd_r[0];
  assign out_chan.forward_y = out_fwd_r[1];
  assign out_chan.forward_z = out_fwd_r[2];
  assign out_chan.right_x   = out_right_r[0];
  assign out_chan.right_y   = out_right_r[1];
  assign out_chan.right_z   = out_right_r[2];
  assign out_chan.up_x      = out_up_r[0];
  assign out_chan.up_y      = out_up_r[1];
  assign out_chan.up_z      = out_up_r[2];

  // skid only fills behind a held output
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry without a pending output");

  // right is perpendicular to down, so its y part is always zero
  assert property (@(posedge clk) disable iff (!rst_n) r_valid |-> (r_n[1] == '0))
    else $error("right vector has nonzero y");

  assert property (@(posedge clk) disable iff (!rst_n)
      f_valid |-> (f_n[0] <= F_ONE && f_n[0] >= -F_ONE &&
                   f_n[1] <= F_ONE && f_n[1] >= -F_ONE &&
                   f_n[2] <= F_ONE && f_n[2] >= -F_ONE))
    else $error("forward component exceeds unit length");

endmodule

// ===== dv/cbb_tb_if.sv =====
// ----------------------------------------------------------------------------
// cbb_tb_if
// Testbench-side note: the channel interfaces come from the design folder;
// this file holds the shared result and setup records used by the testbench.
// ----------------------------------------------------------------------------
package cbb_tb_pkg;
  import cbb_pkg::*;

  typedef struct packed {
    logic signed [CBB_FWD_W-1:0]   fx, fy, fz;
    logic signed [CBB_BASIS_W-1:0] rx, ry, rz;
    logic signed [CBB_BASIS_W-1:0] ux, uy, uz;
  } basis_t;

  typedef struct packed {
    logic signed [CBB_IN_W-1:0] px, py, pz, tx, ty, tz;
  } setup_t;
endpackage

// ===== dv/camera_basis_builder_tb.sv =====
// ----------------------------------------------------------------------------
// camera_basis_builder_tb
// Drives camera setups through the basis builder under random idling and
// back-pressure, predicts each basis in exact fixed point and checks every
// result transfer in order, over several basis_scale settings.
// ----------------------------------------------------------------------------
module camera_basis_builder_tb;
  import cbb_pkg::*;
  import cbb_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = CBB_FRAC_BITS;
  localparam int LATENCY = 3 * FB + 128;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CBB_SCALE_W-1:0] cfg_wdata;

  cbb_in_if  in_chan ();
  cbb_out_if out_chan ();

  camera_basis_builder u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [CBB_SCALE_W-1:0] scale_shadow;
  basis_t basis_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_tail = 0;
  bit hold_sink = 0;
  bit has_row_expect;
  basis_t row_expect;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // scale vector to unit length, largest magnitude first brought into [2^30, 2^31)
  task automatic normalize(input longint v[3], output longint n[3]);
    longint unsigned m[3], mx, sum, s, q;
    bit neg[3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      n = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    s = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (s >> 1)) / s;
      n[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic longint apply_scale(longint n);
    longint unsigned m, q;
    m = n < 0 ? -n : n;
    q = (m * scale_shadow + (64'd1 << (FB - 1))) >> FB;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_basis(input setup_t s, output basis_t b);
    longint d[3], f[3], t[3], r[3], u[3];
    longint lo, hi, x;
    lo = -(64'sd1 <<< 31);
    hi = (64'sd1 <<< 31) - 1;
    d[0] = longint'(s.tx) - longint'(s.px);
    d[1] = longint'(s.ty) - longint'(s.py);
    d[2] = longint'(s.tz) - longint'(s.pz);
    for (int i = 0; i < 3; i++) begin
      x = d[i];
      d[i] = x > hi ? hi : (x < lo ? lo : x);
    end
    normalize(d, f);
    t = '{f[2], 0, -f[0]};
    normalize(t, t);
    for (int i = 0; i < 3; i++) r[i] = apply_scale(t[i]);
    t = '{f[1] * r[2], f[2] * r[0] - f[0] * r[2], -(f[1] * r[0])};
    normalize(t, t);
    for (int i = 0; i < 3; i++) u[i] = apply_scale(t[i]);
    b.fx = CBB_FWD_W'(f[0]);
    b.fy = CBB_FWD_W'(f[1]);
    b.fz = CBB_FWD_W'(f[2]);
    b.rx = CBB_BASIS_W'(r[0]);
    b.ry = CBB_BASIS_W'(r[1]);
    b.rz = CBB_BASIS_W'(r[2]);
    b.ux = CBB_BASIS_W'(u[0]);
    b.uy = CBB_BASIS_W'(u[1]);
    b.uz = CBB_BASIS_W'(u[2]);
  endtask

  // sink side: random stalls, plus a long hold-off on request
  initial begin
    int burst;
    out_chan.ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_chan.ready <= 0;
      end else if (burst > 0) begin
        burst--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 11);
        out_chan.ready <= 0;
      end else begin
        out_chan.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    basis_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.forward_x, out_chan.forward_y, out_chan.forward_z,
              out_chan.right_x, out_chan.right_y, out_chan.right_z,
              out_chan.up_x, out_chan.up_y, out_chan.up_z};
      if (basis_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer %h", $time, got);
      end else begin
        want = basis_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          $display("  fwd exp %0d %0d %0d act %0d %0d %0d", want.fx, want.fy,
                   want.fz, got.fx, got.fy, got.fz);
          $display("  right exp %0d %0d %0d act %0d %0d %0d", want.rx, want.ry,
                   want.rz, got.rx, got.ry, got.rz);
          $display("  up exp %0d %0d %0d act %0d %0d %0d", want.ux, want.uy,
                   want.uz, got.ux, got.uy, got.uz);
        end
      end
    end
  end

  // one transfer; queue is loaded in the accept cycle, valid stays up so
  // the next call can follow back to back
  task automatic send_setup(input setup_t s, input bit allow_gap);
    basis_t b;
    if (allow_gap && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    predict_basis(s, b);
    if (has_row_expect && b !== row_expect) begin
      errors++;
      $display("%0t: table row expected %h predicted %h", $time, row_expect, b);
    end
    in_chan.valid <= 1;
    {in_chan.position_x, in_chan.position_y, in_chan.position_z,
     in_chan.target_x, in_chan.target_y, in_chan.target_z} <= s;
    do @(posedge clk); while (!in_chan.ready);
    basis_q.push_back(b);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    while (basis_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_scale(input logic [CBB_SCALE_W-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    scale_shadow = v;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 255)) - 128;
      3: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  function automatic setup_t rand_setup();
    setup_t s;
    s = {rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: s.tx = s.px;
      1: begin s.tx = s.px; s.tz = s.pz; end  // looking straight along y
      2: s = {s.px, s.py, s.pz, s.px, s.py, s.pz};
      default: ;
    endcase
    return s;
  endfunction

  typedef struct {
    setup_t s;
    bit     known;
    basis_t b;
  } row_t;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  row_t rows[] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1, '0},
    '{'{5, -7, 9, 5, -7, 9}, 1, '0},
    '{'{0, 0, 0, 0, ONE, 0}, 1, '{0, 18'sd65536, 0, 0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, -ONE, 0}, 1, '{0, -18'sd65536, 0, 0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, ONE}, 1,
      '{0, 0, 18'sd65536, 20'sd98304, 0, 0, 0, 20'sd98304, 0}},
    '{'{0, 0, 0, ONE, 0, 0}, 0, '0},
    '{'{MINV, MINV, MINV, MAXV, MAXV, MAXV}, 0, '0},
    '{'{MAXV, MAXV, MAXV, MINV, MINV, MINV}, 0, '0},
    '{'{MAXV, 0, MINV, MINV, 0, MAXV}, 0, '0},
    '{'{0, 0, 0, 1, 0, 0}, 0, '0},
    '{'{0, 0, 0, 1, 1, 1}, 0, '0},
    '{'{0, 0, 0, -1, -1, -1}, 0, '0},
    '{'{0, 0, 0, 3, -2, 1}, 0, '0},
    '{'{-ONE, 2 * ONE, 0, 3 * ONE, -ONE, -5 * ONE}, 0, '0},
    '{'{32'sh12345678, 32'sh5eadbeef, 32'sh0badf00d, 32'sh87654321,
        32'sh01234567, 32'shedcba987}, 0, '0},
    '{'{0, MINV, 0, 0, MAXV, 0}, 0, '0}
  };

  logic [CBB_SCALE_W-1:0] scales[] = '{19'h7ffff, 0, 262144, 1, 65536};

  initial begin
    in_chan.valid <= 0;
    {in_chan.position_x, in_chan.position_y, in_chan.position_z,
     in_chan.target_x, in_chan.target_y, in_chan.target_z} <= '0;
    cfg_we <= 0;
    cfg_wdata <= '0;
    rst_n <= 0;
    has_row_expect = 0;
    scale_shadow = CBB_SCALE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table at the reset scale
    foreach (rows[i]) begin
      has_row_expect = rows[i].known;
      row_expect = rows[i].b;
      send_setup(rows[i].s, 1);
    end
    has_row_expect = 0;
    drain();

    // random phases over several scales
    foreach (scales[k]) begin
      write_scale(scales[k]);
      repeat (20) send_setup(rand_setup(), 1);
      // edges of the directed set at this scale too
      send_setup('{0, 0, 0, 0, 0, ONE}, 1);
      send_setup('{MINV, MINV, MINV, MAXV, MAXV, MAXV}, 1);
      drain();
    end

    write_scale($urandom_range(0, 19'h7ffff));
    // long sink hold-off while the source keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (LATENCY + 60) @(posedge clk);
        hold_sink = 0;
      end
      begin
        repeat (LATENCY + 40) send_setup(rand_setup(), 0);
        in_chan.valid <= 0;
      end
    join
    drain();

    write_scale(CBB_SCALE_RESET);
    repeat (200) send_setup(rand_setup(), 1);
    quiet_tail = 1;
    repeat (100) send_setup(rand_setup(), 0);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
